FILE: design/a85lw_pkg.sv
package a85lw_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_Z     = 8'd122;
    localparam logic [7:0] CHAR_TILDE = 8'd126;
    localparam logic [7:0] CHAR_GT    = 8'd62;
    localparam logic [7:0] CHAR_BIAS  = 8'd33;

    // Base-85 conversion constants.
    localparam int          NUM_DIGITS  = 5;
    localparam int          NUM_DIV     = 4;
    localparam logic [31:0] RADIX       = 32'd85;
    localparam logic [31:0] RECIP       = 32'd3233857728;  // floor(2^38 / 85)
    localparam int          RECIP_SHIFT = 38;
    localparam int          QEST_W      = 64 - RECIP_SHIFT;

    // Line width handling.
    localparam logic [9:0]  WIDTH_RESET = 10'd75;
    localparam logic [10:0] MAX_WIDTH   = 11'd1020;
    localparam logic [10:0] DIV5_RECIP  = 11'd1639;         // ceil(2^13 / 5)
    localparam int          DIV5_SHIFT  = 13;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [NUM_DIGITS-1:0][6:0] t_digits;

    // One classified group on its way through the digit pipeline.
    typedef struct packed {
        logic [31:0]       val;
        logic [QEST_W-1:0] qest;
        t_digits           dig;
        logic              zero;
        logic [2:0]        cnt;
        logic              eod;
    } t_work;

    // One group as handed from front to back.
    typedef struct packed {
        t_digits    dig;
        logic       zero;
        logic [2:0] cnt;
        logic       eod;
    } t_entry;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DATA,
        PH_NL,
        PH_EOD,
        PH_TILDE,
        PH_GT,
        PH_END
    } t_phase;

    // Effective line width: rounded up to a multiple of five, at least five,
    // at most 1020.
    function automatic logic [9:0] eff_width(input logic [9:0] lw);
        logic [10:0] x;
        logic [21:0] prod;
        logic [8:0]  q;
        logic [10:0] w;
        x    = (lw == 10'd0) ? 11'd5 : ({1'b0, lw} + 11'd4);
        prod = 22'(x) * 22'(DIV5_RECIP);
        q    = prod[DIV5_SHIFT +: 9];
        w    = 11'(q) * 11'd5;
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        return w[9:0];
    endfunction

endpackage

FILE: design/a85lw_front.sv
module a85lw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_byte0,
    input  logic [7:0]         i_byte1,
    input  logic [7:0]         i_byte2,
    input  logic [7:0]         i_byte3,
    input  logic [2:0]         i_byte_count,
    input  logic               i_append_eod,
    output logic               o_ent_valid,
    output a85lw_pkg::t_entry  o_ent,
    input  logic               i_ent_ready
);

    localparam int NUM_STG = 2 * a85lw_pkg::NUM_DIV + 1;

    a85lw_pkg::t_work r_stg [NUM_STG];
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] rdy;
    a85lw_pkg::t_work   in_work;
    logic               keep;
    logic [2:0]         cnt;

    // Stall chain: a stage can load when it is empty or its beat moves on.
    always_comb begin
        rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || i_ent_ready;
        for (int s = NUM_STG - 2; s >= 0; s--) begin
            rdy[s] = !r_vld[s] || rdy[s+1];
        end
    end

    assign o_full = !rdy[0];

    // Classify the incoming group: clamp the count, mask unused bytes.
    always_comb begin
        cnt = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        in_work.val  = {i_byte0,
                        (cnt >= 3'd2) ? i_byte1 : 8'd0,
                        (cnt >= 3'd3) ? i_byte2 : 8'd0,
                        (cnt >= 3'd4) ? i_byte3 : 8'd0};
        if (cnt == 3'd0) begin
            in_work.val[31:24] = 8'd0;
        end
        in_work.qest = '0;
        in_work.dig  = '0;
        in_work.zero = (cnt == 3'd4) && (in_work.val == 32'd0);
        in_work.cnt  = cnt;
        in_work.eod  = i_append_eod;
        // A group with no bytes and no end marker gives no characters.
        keep = i_push && rdy[0] && ((cnt != 3'd0) || i_append_eod);
    end

    // Valid bits of the pipeline.
    always_comb begin
        n_vld[0] = rdy[0] ? keep : r_vld[0];
        for (int s = 1; s < NUM_STG; s++) begin
            n_vld[s] = rdy[s] ? r_vld[s-1] : r_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_stg[0] <= in_work;
        end
    end

    // Each divider peels off the lowest base-85 digit in two stages: a
    // reciprocal multiply, then a remainder with a single correction.
    for (genvar k = 0; k < a85lw_pkg::NUM_DIV; k++) begin : g_div
        a85lw_pkg::t_work n_a;
        a85lw_pkg::t_work n_b;
        logic [63:0]      prod;
        logic [31:0]      rem;
        logic [31:0]      quo;

        always_comb begin
            n_a  = r_stg[2*k];
            prod = 64'(r_stg[2*k].val) * 64'(a85lw_pkg::RECIP);
            n_a.qest = prod[63:a85lw_pkg::RECIP_SHIFT];
        end

        always_comb begin
            n_b = r_stg[2*k+1];
            quo = 32'(r_stg[2*k+1].qest);
            rem = r_stg[2*k+1].val - quo * a85lw_pkg::RADIX;
            if (rem >= a85lw_pkg::RADIX) begin
                rem = rem - a85lw_pkg::RADIX;
                quo = quo + 32'd1;
            end
            n_b.val = quo;
            n_b.dig[a85lw_pkg::NUM_DIGITS-1-k] = rem[6:0];
        end

        always_ff @(posedge i_clk) begin
            if (rdy[2*k+1] && r_vld[2*k]) begin
                r_stg[2*k+1] <= n_a;
            end
            if (rdy[2*k+2] && r_vld[2*k+1]) begin
                r_stg[2*k+2] <= n_b;
            end
        end
    end

    // The last quotient is the leading digit.
    always_comb begin
        o_ent.dig    = r_stg[NUM_STG-1].dig;
        o_ent.dig[0] = r_stg[NUM_STG-1].val[6:0];
        o_ent.zero   = r_stg[NUM_STG-1].zero;
        o_ent.cnt    = r_stg[NUM_STG-1].cnt;
        o_ent.eod    = r_stg[NUM_STG-1].eod;
    end

    assign o_ent_valid = r_vld[NUM_STG-1];

    // A stalled group at the pipeline end keeps its place and contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STG-1] && !i_ent_ready |=> r_vld[NUM_STG-1] && $stable(r_stg[NUM_STG-1]))
        else $error("front: stalled group changed");

    // Every digit leaving the pipeline is a base-85 digit.
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STG-1] |-> (r_stg[NUM_STG-1].val < 32'd85) &&
            (o_ent.dig[1] < 7'd85) && (o_ent.dig[2] < 7'd85) &&
            (o_ent.dig[3] < 7'd85) && (o_ent.dig[4] < 7'd85))
        else $error("front: digit out of range");

endmodule

FILE: design/a85lw_fifo.sv
module a85lw_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_valid,
    input  a85lw_pkg::t_entry  i_wr_data,
    output logic               o_wr_ready,
    output logic               o_rd_valid,
    output a85lw_pkg::t_entry  o_rd_data,
    input  logic               i_rd_pop
);

    localparam int AW = a85lw_pkg::FIFO_AW;

    a85lw_pkg::t_entry r_mem [a85lw_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          wr;
    logic          rd;

    assign o_wr_ready = (r_count != (AW+1)'(a85lw_pkg::FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = i_rd_pop && o_rd_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // The fill count agrees with the pointers and never passes the depth.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= (AW+1)'(a85lw_pkg::FIFO_DEPTH)) &&
        (AW'(r_count) == AW'(r_wr_ptr - r_rd_ptr)))
        else $error("fifo: count out of step with pointers");

endmodule

FILE: design/a85lw_back.sv
module a85lw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [9:0]         i_width,
    input  logic               i_ent_valid,
    input  a85lw_pkg::t_entry  i_ent,
    output logic               o_ent_pop,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_char,
    output logic               o_last_char
);

    a85lw_pkg::t_phase r_phase;
    a85lw_pkg::t_phase n_phase;
    a85lw_pkg::t_phase phase;
    logic [2:0]  r_idx;
    logic [2:0]  n_idx;
    logic [9:0]  r_col;
    logic [9:0]  n_col;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;
    logic        step;
    logic        gen_last;
    logic [7:0]  gen_char;
    logic [9:0]  col_inc;
    logic        wrap;
    logic        more;
    logic [2:0]  last_idx;

    assign step     = i_ent_valid && (!r_out_valid || pop);
    assign col_inc  = r_col + 10'd1;
    assign wrap     = (col_inc >= i_width);
    assign last_idx = i_ent.zero ? 3'd0 : i_ent.cnt;
    assign more     = (r_idx != last_idx);

    // Phase of the character made this cycle; a fresh group starts with its
    // data characters, or with the end marker when it has none.
    always_comb begin
        if (r_phase == a85lw_pkg::PH_IDLE) begin
            phase = (i_ent.cnt != 3'd0) ? a85lw_pkg::PH_DATA : a85lw_pkg::PH_EOD;
        end else begin
            phase = r_phase;
        end
    end

    // Character sequencer.
    always_comb begin
        gen_char = a85lw_pkg::CHAR_NL;
        gen_last = 1'b0;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_col    = r_col;
        unique case (phase)
            a85lw_pkg::PH_DATA: begin
                gen_char = i_ent.zero ? a85lw_pkg::CHAR_Z
                                      : a85lw_pkg::CHAR_BIAS + {1'b0, i_ent.dig[r_idx]};
                if (wrap) begin
                    n_col   = '0;
                    n_phase = a85lw_pkg::PH_NL;
                end else begin
                    n_col = col_inc;
                    if (more) begin
                        n_idx   = r_idx + 3'd1;
                        n_phase = a85lw_pkg::PH_DATA;
                    end else if (i_ent.eod) begin
                        n_phase = a85lw_pkg::PH_EOD;
                    end else begin
                        gen_last = 1'b1;
                    end
                end
            end
            a85lw_pkg::PH_NL: begin
                gen_char = a85lw_pkg::CHAR_NL;
                if (more) begin
                    n_idx   = r_idx + 3'd1;
                    n_phase = a85lw_pkg::PH_DATA;
                end else if (i_ent.eod) begin
                    n_phase = a85lw_pkg::PH_EOD;
                end else begin
                    gen_last = 1'b1;
                end
            end
            a85lw_pkg::PH_EOD: begin
                // Break the line first if the marker would not fit.
                if (({1'b0, r_col} + 11'd2) > {1'b0, i_width}) begin
                    gen_char = a85lw_pkg::CHAR_NL;
                    n_phase  = a85lw_pkg::PH_TILDE;
                end else begin
                    gen_char = a85lw_pkg::CHAR_TILDE;
                    n_phase  = a85lw_pkg::PH_GT;
                end
            end
            a85lw_pkg::PH_TILDE: begin
                gen_char = a85lw_pkg::CHAR_TILDE;
                n_phase  = a85lw_pkg::PH_GT;
            end
            a85lw_pkg::PH_GT: begin
                gen_char = a85lw_pkg::CHAR_GT;
                n_phase  = a85lw_pkg::PH_END;
            end
            a85lw_pkg::PH_END: begin
                gen_char = a85lw_pkg::CHAR_NL;
                n_col    = '0;
                gen_last = 1'b1;
            end
            default: begin
                gen_char = a85lw_pkg::CHAR_NL;
            end
        endcase
        if (gen_last) begin
            n_phase = a85lw_pkg::PH_IDLE;
            n_idx   = '0;
        end
    end

    assign o_ent_pop = step && gen_last;

    // Sequencer state and line column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= a85lw_pkg::PH_IDLE;
            r_idx   <= '0;
            r_col   <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_col   <= n_col;
        end
    end

    // Output register: one character beat waits here for the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_char <= gen_char;
            r_out_last <= gen_last;
        end
    end

    assign empty       = !r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

    // A data character that fills the line is followed by a newline.
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (phase == a85lw_pkg::PH_DATA) && wrap |=>
            (r_phase == a85lw_pkg::PH_NL) && (r_col == 10'd0))
        else $error("back: missing line break");

    // A group that ends with the marker leaves the column at zero.
    a_eod_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && gen_last && i_ent.eod |=> (r_col == 10'd0) &&
            (r_out_char == a85lw_pkg::CHAR_NL))
        else $error("back: end marker left column nonzero");

endmodule

FILE: design/ascii85_encoder_line_wrap_top.sv
// Channel   Direction  Handshake             Payload
// input     in         push / full           i_byte0..i_byte3, i_byte_count, i_append_eod
// result    out        empty / pop           o_out_char, o_last_char
// config    in         i_cfg_we              i_cfg_wdata (line width)
//
// A group taken while full is low passes the front pipeline and the queue to the
// character sequencer; its characters leave through the output register.
// Characters leave one per cycle while pop stays high and groups are waiting, so
// a four-byte group gives five characters (one for an all-zero group) plus any line breaks.
// Synchronous active-low reset empties the pipeline and queue, clears the
// column and sets the width to 75; a result stall fills queue and pipeline first.
module ascii85_encoder_line_wrap_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_byte0,
    input  logic [7:0] i_byte1,
    input  logic [7:0] i_byte2,
    input  logic [7:0] i_byte3,
    input  logic [2:0] i_byte_count,
    input  logic       i_append_eod,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_last_char,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata
);

    logic [9:0]        r_width;
    logic              front_valid;
    a85lw_pkg::t_entry front_ent;
    logic              fifo_ready;
    logic              q_valid;
    a85lw_pkg::t_entry q_ent;
    logic              q_pop;

    // Effective line width, worked out when the register is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= a85lw_pkg::eff_width(a85lw_pkg::WIDTH_RESET);
        end else if (i_cfg_we) begin
            r_width <= a85lw_pkg::eff_width(i_cfg_wdata);
        end
    end

    a85lw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_byte0      (i_byte0),
        .i_byte1      (i_byte1),
        .i_byte2      (i_byte2),
        .i_byte3      (i_byte3),
        .i_byte_count (i_byte_count),
        .i_append_eod (i_append_eod),
        .o_ent_valid  (front_valid),
        .o_ent        (front_ent),
        .i_ent_ready  (fifo_ready)
    );

    a85lw_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .i_wr_data  (front_ent),
        .o_wr_ready (fifo_ready),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_ent),
        .i_rd_pop   (q_pop)
    );

    a85lw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_ent_valid (q_valid),
        .i_ent       (q_ent),
        .o_ent_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

FILE: tb/ascii85_encoder_line_wrap_top_tb.sv
module ascii85_encoder_line_wrap_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 22;
    localparam int HOLD_PHASE      = 2;

    // One input group as it appears on the ports.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] cnt;
        logic       eod;
    } t_group;

    // One expected output character.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_expected_char;

    typedef logic [7:0] t_char_q[$];

    // One row of the directed table: a width write or a group.
    typedef struct {
        bit         is_cfg;
        logic [9:0] width;
        t_group     grp;
        bit         typed;
        string      txt;
    } t_directed_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_byte0;
    logic [7:0] i_byte1;
    logic [7:0] i_byte2;
    logic [7:0] i_byte3;
    logic [2:0] i_byte_count;
    logic       i_append_eod;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_char;
    logic       o_last_char;
    logic       i_cfg_we;
    logic [9:0] i_cfg_wdata;

    // Encoder state as the checker sees it.
    logic [9:0] line_width;
    logic [9:0] line_column;

    t_expected_char expected_chars[$];
    t_directed_row  directed_rows[$];
    int             errors;
    bit             idle_enable;
    bit             hold_request;

    ascii85_encoder_line_wrap_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_byte0      (i_byte0),
        .i_byte1      (i_byte1),
        .i_byte2      (i_byte2),
        .i_byte3      (i_byte3),
        .i_byte_count (i_byte_count),
        .i_append_eod (i_append_eod),
        .empty        (empty),
        .pop          (pop),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Characters the encoder must produce for one group; updates the column.
    function automatic void encode_group(input t_group g, output t_char_q chars);
        int unsigned width;
        int unsigned count;
        int unsigned word;
        int unsigned v;
        int unsigned i;
        int unsigned digits[5];
        logic [7:0]  bytes[4];
        t_char_q     data;
        width = (line_width == 10'd0) ? 1 : line_width;
        width = ((width + 4) / 5) * 5;
        if (width > 1020) begin
            width = 1020;
        end
        count = (g.cnt > 3'd4) ? 4 : g.cnt;
        bytes = '{g.b0, g.b1, g.b2, g.b3};
        chars = {};
        data  = {};
        if (count > 0) begin
            word = 0;
            for (i = 0; i < 4; i++) begin
                word = (word << 8) | ((i < count) ? bytes[i] : 8'd0);
            end
            if (count == 4 && word == 0) begin
                data.push_back(a85lw_pkg::CHAR_Z);
            end else begin
                v = word;
                digits[0] = v / 52200625; v = v % 52200625;
                digits[1] = v / 614125;   v = v % 614125;
                digits[2] = v / 7225;     v = v % 7225;
                digits[3] = v / 85;
                digits[4] = v % 85;
                for (i = 0; i < count + 1; i++) begin
                    data.push_back(8'(a85lw_pkg::CHAR_BIAS + digits[i]));
                end
            end
        end
        // Each data character advances the column and may end the line.
        foreach (data[k]) begin
            chars.push_back(data[k]);
            line_column = line_column + 10'd1;
            if (line_column >= width) begin
                chars.push_back(a85lw_pkg::CHAR_NL);
                line_column = '0;
            end
        end
        // End-of-data marker, moved to a fresh line when it would not fit.
        if (g.eod) begin
            if (2 + line_column > width) begin
                chars.push_back(a85lw_pkg::CHAR_NL);
            end
            chars.push_back(a85lw_pkg::CHAR_TILDE);
            chars.push_back(a85lw_pkg::CHAR_GT);
            chars.push_back(a85lw_pkg::CHAR_NL);
            line_column = '0;
        end
    endfunction

    function automatic void add_item_row(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] cnt, input bit eod,
                                         input bit typed, input string txt);
        t_directed_row row;
        row.is_cfg = 1'b0;
        row.width  = '0;
        row.grp    = '{b0, b1, b2, b3, cnt, eod};
        row.typed  = typed;
        row.txt    = txt;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input logic [9:0] width);
        t_directed_row row;
        row.is_cfg = 1'b1;
        row.width  = width;
        row.grp    = '0;
        row.typed  = 1'b0;
        row.txt    = "";
        directed_rows.push_back(row);
    endfunction

    function automatic t_group random_group();
        t_group      g;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        g.b0 = 8'($urandom_range(0, 255));
        g.b1 = 8'($urandom_range(0, 255));
        g.b2 = 8'($urandom_range(0, 255));
        g.b3 = 8'($urandom_range(0, 255));
        if (kind < 10) begin
            g.b0 = 8'h00; g.b1 = 8'h00; g.b2 = 8'h00; g.b3 = 8'h00;
        end else if (kind < 15) begin
            g.b0 = 8'hFF; g.b1 = 8'hFF; g.b2 = 8'hFF; g.b3 = 8'hFF;
        end
        // Mostly full groups, now and then a final group of one to four bytes with the marker.
        g.cnt = 3'd4;
        g.eod = 1'b0;
        if ($urandom_range(0, 7) == 0) begin
            g.eod = 1'b1;
            g.cnt = 3'($urandom_range(1, 4));
        end
        // Noise: any count, including zero and out-of-range values.
        if (kind >= 85) begin
            g.cnt = 3'($urandom_range(0, 7));
            g.eod = 1'($urandom_range(0, 1));
        end
        return g;
    endfunction

    function automatic logic [9:0] phase_width(input int p);
        unique case (p)
            1: begin
                return 10'd0;
            end
            2: begin
                return 10'd1023;
            end
            3: begin
                return 10'd5;
            end
            4: begin
                return 10'd1;
            end
            5: begin
                return 10'd1020;
            end
            6: begin
                return 10'd6;
            end
            8: begin
                return a85lw_pkg::WIDTH_RESET;
            end
            default: begin
                return 10'($urandom_range(1, 1023));
            end
        endcase
    endfunction

    // Offer one group, wait for the beat, then queue what it must produce.
    task automatic send_group(input t_group g, input bit typed, input string txt);
        t_char_q chars;
        push         <= 1'b1;
        i_byte0      <= g.b0;
        i_byte1      <= g.b1;
        i_byte2      <= g.b2;
        i_byte3      <= g.b3;
        i_byte_count <= g.cnt;
        i_append_eod <= g.eod;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        encode_group(g, chars);
        if (typed) begin
            chars = {};
            for (int i = 0; i < txt.len(); i++) begin
                chars.push_back(txt[i]);
            end
        end
        foreach (chars[k]) begin
            expected_chars.push_back('{chars[k], k == chars.size() - 1});
        end
    endtask

    task automatic sender_gap();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Stop offering, let every expected character out, then let the pipe empty.
    task automatic drain_and_settle();
        push <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_width(input logic [9:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        line_width  = value;
    endtask

    // Result side: pops with random idle bursts and one long hold-off.
    initial begin
        pop <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare every accepted character with the oldest expectation.
    always @(posedge i_clk) begin
        t_expected_char exp_char;
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, o_out_char, o_last_char);
                errors++;
            end else begin
                exp_char = expected_chars.pop_front();
                if (o_out_char !== exp_char.ch) begin
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, exp_char.ch, o_out_char);
                    errors++;
                end
                if (o_last_char !== exp_char.last) begin
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, exp_char.last, o_last_char);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        errors       = 0;
        idle_enable  = 1'b1;
        hold_request = 1'b0;
        line_width   = a85lw_pkg::WIDTH_RESET;
        line_column  = '0;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_byte0      <= '0;
        i_byte1      <= '0;
        i_byte2      <= '0;
        i_byte3      <= '0;
        i_byte_count <= '0;
        i_append_eod <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;

        // Directed rows, starting from the reset width of 75 and column zero.
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 1'b1, "~>\n");
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0, 1'b1, "");
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0, 1'b1, "z");
        add_item_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b1, "s8W-!");
        add_item_row(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1, 1'b1, 1'b1, "!!~>\n");
        add_item_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1, 1'b1, "s8W-!~>\n");
        add_item_row(8'h12, 8'h34, 8'h56, 8'h78, 3'd2, 1'b0, 1'b0, "");
        add_item_row(8'hAB, 8'hCD, 8'hEF, 8'h01, 3'd3, 1'b0, 1'b0, "");
        // A count above four counts as four, so an all-zero word is still 'z'.
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 1'b0, 1'b1, "z");
        add_item_row(8'h80, 8'h00, 8'h00, 8'h01, 3'd5, 1'b1, 1'b0, "");
        // A zero partial group never becomes 'z'.
        add_item_row(8'h00, 8'h00, 8'h00, 8'hFF, 3'd3, 1'b0, 1'b1, "!!!!");
        add_item_row(8'hFF, 8'h00, 8'hFF, 8'h00, 3'd6, 1'b0, 1'b0, "");
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 1'b1, "~>\n");
        // Width 5: the marker does not fit after four characters.
        add_cfg_row(10'd3);
        add_item_row(8'hFF, 8'hFF, 8'hFF, 8'h55, 3'd3, 1'b0, 1'b0, "");
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 1'b1, "\n~>\n");
        add_item_row(8'h01, 8'h02, 8'h03, 8'h04, 3'd4, 1'b0, 1'b0, "");
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b1, 1'b1, "z~>\n");
        // A zero width behaves as width 5.
        add_cfg_row(10'd0);
        add_item_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1, 1'b1, "s8W-!\n~>\n");
        add_item_row(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b0, "");
        // Widest setting, saturated at 1020.
        add_cfg_row(10'd1023);
        add_item_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b1, "s8W-!");
        add_item_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0, 1'b1, "");
        // Leave the column at 15, then lower the width below it.
        add_cfg_row(a85lw_pkg::WIDTH_RESET);
        add_item_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b1, "s8W-!");
        add_item_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0, 1'b1, "s8W-!");
        add_cfg_row(10'd1);
        add_item_row(8'h11, 8'h22, 8'h33, 8'h44, 3'd4, 1'b0, 1'b0, "");
        add_item_row(8'hA5, 8'h5A, 8'h00, 8'h00, 3'd2, 1'b1, 1'b0, "");

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                drain_and_settle();
                write_line_width(directed_rows[i].width);
            end else begin
                send_group(directed_rows[i].grp, directed_rows[i].typed, directed_rows[i].txt);
                sender_gap();
            end
        end

        // Random part, one width setting per phase; the last phase runs without idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_settle();
            write_line_width(phase_width(p));
            idle_enable = (p != NUM_PHASES - 1);
            if (p == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            for (int r = 0; r < ITEMS_PER_PHASE; r++) begin
                send_group(random_group(), 1'b0, "");
                if (p != HOLD_PHASE) begin
                    sender_gap();
                end
            end
        end

        drain_and_settle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/a85lw_pkg.sv
design/a85lw_front.sv
design/a85lw_fifo.sv
design/a85lw_back.sv
design/ascii85_encoder_line_wrap_top.sv
tb/ascii85_encoder_line_wrap_top_tb.sv
